>>> hw/rtl/smm_pkg.sv
// Shared constants, codes and types of the shift-or substring matcher.
`default_nettype none
package smm_pkg;

  // Needle store depth and field widths
  localparam int MAX_NEEDLE = 63;
  localparam int POS_W      = 16;
  localparam int LEN_W      = 6;
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 6;
  localparam int BYTE_W     = 8;
  localparam int START_W    = 16;
  localparam int VEC_W      = 64;
  localparam int NIDX_W     = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

  // Mask table: one entry per byte value
  localparam int MASK_DEPTH = 1 << BYTE_W;
  localparam int MASK_AW    = BYTE_W;

  // Match vector after a start: all ones but bit zero
  localparam logic [VEC_W-1:0] VEC_START = ~VEC_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_BYTE  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic               match_now;
    logic [START_W-1:0] match_start;
    logic               found_earlier;
  } result_t;

  typedef struct packed {
    logic                  en;
    logic [MASK_AW-1:0]    addr;
    logic [MAX_NEEDLE-1:0] data;
  } mask_wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/smm_mask_table.sv
// Mismatch mask table, one row per byte value, with a clearing pass after reset.
`default_nettype none
module smm_mask_table (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire smm_pkg::mask_wr_t              wr_i,
  input  wire logic [smm_pkg::MASK_AW-1:0]    rd_addr_i,
  output logic      [smm_pkg::MAX_NEEDLE-1:0] rd_data_o,
  output logic                                ready_o
);

  logic [smm_pkg::MAX_NEEDLE-1:0] mem [smm_pkg::MASK_DEPTH];
  logic [smm_pkg::MAX_NEEDLE-1:0] rd_data_q;
  logic                           clr_active_q, clr_active_d;
  logic [smm_pkg::MASK_AW-1:0]    clr_addr_q, clr_addr_d;

  // Advance the clearing pass one row a cycle, stop after the last row
  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + smm_pkg::MASK_AW'(1);
      if (clr_addr_q == {smm_pkg::MASK_AW{1'b1}}) begin
        clr_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
    end
  end

  // Write a row (clearing first), read through an output register
  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      mem[clr_addr_q] <= '1;
    end else if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = ~clr_active_q;

endmodule
`default_nettype wire

>>> hw/rtl/smm_needle_store.sv
// Needle byte store: write and read-old-data at one address per cycle.
`default_nettype none
module smm_needle_store (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [smm_pkg::NIDX_W-1:0]   addr_i,
  input  wire logic [smm_pkg::BYTE_W-1:0]   wdata_i,
  output logic      [smm_pkg::BYTE_W-1:0]   rdata_o
);

  logic [smm_pkg::BYTE_W-1:0] mem [smm_pkg::MAX_NEEDLE];
  logic [smm_pkg::BYTE_W-1:0] rdata_q;

  // Return the byte held before this write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/smm_out_buf.sv
// Two-entry result buffer that parts the output from the pipeline.
`default_nettype none
module smm_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire smm_pkg::result_t push_data_i,
  input  wire logic             stall_i,
  output logic                  valid_o,
  output smm_pkg::result_t      data_o,
  output logic [1:0]            level_o
);

  smm_pkg::result_t ent_q [2];
  logic [1:0]       level_q, level_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic             wr_ptr_q, wr_ptr_d;
  logic             pop;

  assign valid_o = (level_q != 2'd0);
  assign pop     = valid_o & ~stall_i;
  assign data_o  = ent_q[rd_ptr_q];
  assign level_o = level_q;

  // Advance pointers and level
  always_comb begin
    rd_ptr_d = rd_ptr_q ^ pop;
    wr_ptr_d = wr_ptr_q ^ push_i;
    level_d  = level_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= 2'd0;
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
    end else begin
      level_q  <= level_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
    end
  end

  // Hold each word until taken
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/shift_or_substring_matcher.sv
// Path: an accepted input word is registered in stage one, then pushed into the result
// buffer, from which it is offered. Throughput: one start or haystack word per cycle,
// bound by the mask table read port, while no clearing pass, needle load or full result
// buffer holds off input; a needle load holds off further input while it rewrites up to two
// table rows over one write port. Reset: position, found flag and needle length clear at
// once, the match vector takes its start value, and the mask table then runs a clearing
// pass over every row during which no input word is accepted.
// Shift-or substring matcher top level: table lookup, vector update, result buffer.
`default_nettype none
module shift_or_substring_matcher (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [smm_pkg::LEN_W-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [smm_pkg::CMD_W-1:0]    command_i,
  input  wire logic [smm_pkg::IDX_W-1:0]    needle_index_i,
  input  wire logic [smm_pkg::BYTE_W-1:0]   byte_value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              match_now_o,
  output logic      [smm_pkg::START_W-1:0]  match_start_o,
  output logic                              found_earlier_o
);

  localparam logic [smm_pkg::IDX_W-1:0] IdxLimit = smm_pkg::IDX_W'(smm_pkg::MAX_NEEDLE);
  localparam logic [smm_pkg::LEN_W-1:0] LenLimit = smm_pkg::LEN_W'(smm_pkg::MAX_NEEDLE);

  logic accept;

  // Stage one: word whose table row arrives this cycle
  logic                         s1_valid_q;
  logic [smm_pkg::CMD_W-1:0]    s1_cmd_q;
  logic [smm_pkg::IDX_W-1:0]    s1_idx_q;
  logic [smm_pkg::BYTE_W-1:0]   s1_byte_q;
  // Stage two: second row rewrite of a needle load
  logic                         s2_valid_q;
  logic [smm_pkg::IDX_W-1:0]    s2_idx_q;
  logic [smm_pkg::BYTE_W-1:0]   s2_byte_q;
  logic [smm_pkg::BYTE_W-1:0]   s2_old_q;

  logic [smm_pkg::LEN_W-1:0]    len_q;
  logic [smm_pkg::VEC_W-1:0]    mv_q, mv_d;
  logic [smm_pkg::POS_W-1:0]    pos_q, pos_d;
  logic                         seen_q, seen_d;

  logic [smm_pkg::MAX_NEEDLE-1:0] tbl_rdata;
  logic [smm_pkg::MASK_AW-1:0]    tbl_raddr;
  logic                           tbl_ready;
  smm_pkg::mask_wr_t              tbl_wr;
  logic [smm_pkg::BYTE_W-1:0]     needle_old;

  logic s1_load, s1_idx_ok, s2_idx_ok, ld_busy;
  logic [smm_pkg::MAX_NEEDLE-1:0] s1_bit, s2_bit, len_mask;
  logic [smm_pkg::VEC_W-1:0]      mask_full, vec_next;
  logic [smm_pkg::POS_W:0]        pos_inc, len_ext, start_full;
  logic                           hit;
  smm_pkg::result_t               res;

  logic [1:0] buf_level;
  logic [2:0] occ;
  logic       buf_pop;
  smm_pkg::result_t out_data;

  // Configuration: always ready; the user must keep to idle-time writes only, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  // Input flow control: hold off during clearing, needle loads and a full buffer
  assign s1_load = s1_valid_q && (s1_cmd_q == smm_pkg::CMD_LOAD);
  assign ld_busy = s1_load | s2_valid_q;
  assign buf_pop = out_valid_o & ~out_stall_i;
  assign occ     = 3'(buf_level) + 3'(s1_valid_q) - 3'(buf_pop);
  assign in_stall_o = ~tbl_ready | ld_busy | (occ > 3'd1);
  assign accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_load && s1_idx_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= command_i;
      s1_idx_q  <= needle_index_i;
      s1_byte_q <= byte_value_i;
    end
    if (s1_load) begin
      s2_idx_q  <= s1_idx_q;
      s2_byte_q <= s1_byte_q;
      s2_old_q  <= needle_old;
    end
  end

  // Needle store: write on an in-range load, old byte comes back next cycle
  smm_needle_store u_needle (
    .clk_i   (clk_i),
    .we_i    (accept && (command_i == smm_pkg::CMD_LOAD) && (needle_index_i < IdxLimit)),
    .addr_i  (needle_index_i[smm_pkg::NIDX_W-1:0]),
    .wdata_i (byte_value_i),
    .rdata_o (needle_old)
  );

  // Mask table rewrites: clear the bit in the new byte's row, then set it in the old one if it differs
  assign s1_idx_ok = s1_idx_q < IdxLimit;
  assign s2_idx_ok = s2_idx_q < IdxLimit;
  assign s1_bit    = smm_pkg::MAX_NEEDLE'(1) << s1_idx_q[smm_pkg::NIDX_W-1:0];
  assign s2_bit    = smm_pkg::MAX_NEEDLE'(1) << s2_idx_q[smm_pkg::NIDX_W-1:0];

  always_comb begin
    tbl_wr = '0;
    if (s1_load && s1_idx_ok) begin
      tbl_wr.en   = 1'b1;
      tbl_wr.addr = s1_byte_q;
      tbl_wr.data = tbl_rdata & ~s1_bit;
    end else if (s2_valid_q && s2_idx_ok && (s2_old_q != s2_byte_q)) begin
      tbl_wr.en   = 1'b1;
      tbl_wr.addr = s2_old_q;
      tbl_wr.data = tbl_rdata | s2_bit;
    end
  end

  assign tbl_raddr = s1_load ? needle_old : byte_value_i;

  smm_mask_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_addr_i (tbl_raddr),
    .rd_data_o (tbl_rdata),
    .ready_o   (tbl_ready)
  );

  // Force mask bits at and above the needle length to mismatch
  always_comb begin
    for (int i = 0; i < smm_pkg::MAX_NEEDLE; i++) begin
      len_mask[i] = (smm_pkg::LEN_W'(i) >= len_q);
    end
    mask_full = '1;
    mask_full[smm_pkg::MAX_NEEDLE-1:0] = tbl_rdata | len_mask;
    vec_next  = (mv_q | mask_full) << 1;
  end

  // Occurrence start, clamped at zero
  assign pos_inc    = {1'b0, pos_q} + (smm_pkg::POS_W + 1)'(1);
  assign len_ext    = (smm_pkg::POS_W + 1)'(len_q);
  assign start_full = (pos_inc >= len_ext) ? (pos_inc - len_ext) : '0;
  assign hit = (len_q != '0) && (len_q <= LenLimit) && !vec_next[len_q];

  // Update the match state and form the result word
  always_comb begin
    mv_d   = mv_q;
    pos_d  = pos_q;
    seen_d = seen_q;
    res.match_now     = 1'b0;
    res.match_start   = '0;
    res.found_earlier = seen_q;
    case (s1_cmd_q)
      smm_pkg::CMD_START: begin
        mv_d   = smm_pkg::VEC_START;
        pos_d  = '0;
        seen_d = (len_q == '0);
        res.match_now     = (len_q == '0);
        res.found_earlier = 1'b0;
      end
      smm_pkg::CMD_LOAD: begin
      end
      smm_pkg::CMD_BYTE: begin
        mv_d = vec_next;
        if (hit) begin
          res.match_now   = 1'b1;
          res.match_start = smm_pkg::START_W'(start_full);
          seen_d          = 1'b1;
        end
        if (pos_q != {smm_pkg::POS_W{1'b1}}) begin
          pos_d = pos_q + smm_pkg::POS_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q   <= smm_pkg::VEC_START;
      pos_q  <= '0;
      seen_q <= 1'b0;
    end else if (s1_valid_q) begin
      mv_q   <= mv_d;
      pos_q  <= pos_d;
      seen_q <= seen_d;
    end
  end

  // Result buffer
  smm_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (res),
    .stall_i     (out_stall_i),
    .valid_o     (out_valid_o),
    .data_o      (out_data),
    .level_o     (buf_level)
  );

  assign match_now_o     = out_data.match_now;
  assign match_start_o   = out_data.match_start;
  assign found_earlier_o = out_data.found_earlier;

endmodule
`default_nettype wire
